### hdl/lclp_pkg.sv
`default_nettype none

package lclp_pkg;

    // action codes carried in the input tuser
    localparam logic [2:0] ACT_LEFT_BYTE  = 3'd0;
    localparam logic [2:0] ACT_RIGHT_BYTE = 3'd1;
    localparam logic [2:0] ACT_SEC_TICK   = 3'd2;
    localparam logic [2:0] ACT_FRAME_TICK = 3'd3;
    localparam logic [2:0] ACT_BUTTON     = 3'd4;

    // frame headers on the links
    localparam logic [7:0] HDR_LEFT_GEO  = 8'h01;
    localparam logic [7:0] HDR_RIGHT_GEO = 8'h02;
    localparam logic [7:0] HDR_UPDATE    = 8'h03;

    localparam logic [7:0] PAT_WRAP5    = 8'd0;
    localparam logic [7:0] PAT_WRAP2    = 8'd1;
    localparam logic [7:0] BRIGHT_RESET = 8'hFF;
    localparam logic [7:0] BRIGHT_FLOOR = 8'd10;
    localparam logic [7:0] PATTERN_RESET = 8'd1;
    localparam logic [7:0] OWN_LEDS_RESET    = 8'd8;
    localparam logic [7:0] OWN_LETTERS_RESET = 8'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MSG_GEO_LEFT,
        MSG_GEO_RIGHT,
        MSG_UPDATE,
        MSG_TICK
    } t_msg_kind;

    // snapshot of everything a message needs, taken when the item is handled
    typedef struct packed {
        t_msg_kind   kind;
        logic [7:0]  ll_leds;     // geometry sent left
        logic [7:0]  ll_letters;
        logic [7:0]  rl_leds;     // geometry sent right
        logic [7:0]  rl_letters;
        logic [7:0]  bright;
        logic [7:0]  pattern;
        logic [15:0] frame;
    } t_msg;

endpackage

`default_nettype wire

### hdl/lclp_front.sv
`default_nettype none

module lclp_front #(
    parameter int LIFE_START = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_own_leds,
    input  wire logic [7:0]    i_own_letters,
    input  wire logic          i_valid,
    input  wire logic [2:0]    i_action,
    input  wire logic [7:0]    i_byte,
    output logic               o_ready,
    input  wire logic          i_full,
    output logic               o_push,
    output lclp_pkg::t_msg     o_msg
);
    import lclp_pkg::*;

    localparam logic [2:0] LIFE_LOAD = 3'(LIFE_START);

    logic [7:0]  r_leds_l, n_leds_l, r_letters_l, n_letters_l;
    logic [2:0]  r_life_l, n_life_l;
    logic [7:0]  r_leds_r, n_leds_r, r_letters_r, n_letters_r;
    logic [2:0]  r_life_r, n_life_r;
    logic [7:0]  r_pattern, n_pattern, r_bright, n_bright;
    logic [15:0] r_frame, n_frame;
    logic [1:0]  r_lfill, n_lfill;
    logic [1:0]  r_rfill, n_rfill;
    logic [7:0]  r_lbuf [0:2];
    logic [7:0]  r_rbuf [0:1];

    logic        accept;
    logic        lbuf_we, rbuf_we;
    logic [8:0]  total;
    logic [11:0] limit;
    logic [15:0] frame_inc;
    t_msg_kind   kind;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign total   = {1'b0, i_own_leds} + {1'b0, r_leds_r};
    assign limit   = (r_pattern == PAT_WRAP5) ? ({1'b0, total, 2'b00} + {3'b000, total})
                                              : {2'b00, total, 1'b0};
    assign frame_inc = r_frame + 16'd1;

    always_comb begin
        n_leds_l    = r_leds_l;
        n_letters_l = r_letters_l;
        n_life_l    = r_life_l;
        n_leds_r    = r_leds_r;
        n_letters_r = r_letters_r;
        n_life_r    = r_life_r;
        n_pattern   = r_pattern;
        n_frame     = r_frame;
        n_bright    = r_bright;
        n_lfill     = r_lfill;
        n_rfill     = r_rfill;
        lbuf_we     = 1'b0;
        rbuf_we     = 1'b0;
        o_push      = 1'b0;
        kind        = MSG_TICK;
        if (accept) begin
            case (i_action)
                ACT_LEFT_BYTE: begin
                    if (r_lfill != 2'd0 || i_byte == HDR_LEFT_GEO || i_byte == HDR_UPDATE) begin
                        if (r_lfill != 2'd3) begin
                            lbuf_we = 1'b1;
                            n_lfill = r_lfill + 2'd1;
                        end else begin
                            n_lfill = 2'd0;
                            if (r_lbuf[0] == HDR_LEFT_GEO) begin
                                n_life_l = LIFE_LOAD;
                                if (r_leds_l != r_lbuf[1] || r_letters_l != r_lbuf[2] ||
                                    r_bright != i_byte) begin
                                    n_leds_l    = r_lbuf[1];
                                    n_letters_l = r_lbuf[2];
                                    n_bright    = i_byte;
                                    o_push      = 1'b1;
                                    kind        = MSG_GEO_RIGHT;
                                end
                            end else begin
                                n_pattern = r_lbuf[1];
                                n_frame   = {r_lbuf[2], i_byte};
                                o_push    = 1'b1;
                                kind      = MSG_UPDATE;
                            end
                        end
                    end
                end
                ACT_RIGHT_BYTE: begin
                    if (r_rfill != 2'd0 || i_byte == HDR_RIGHT_GEO) begin
                        if (r_rfill != 2'd2) begin
                            rbuf_we = 1'b1;
                            n_rfill = r_rfill + 2'd1;
                        end else begin
                            n_rfill  = 2'd0;
                            n_life_r = LIFE_LOAD;
                            if (r_leds_r != r_rbuf[1] || r_letters_r != i_byte) begin
                                n_leds_r    = r_rbuf[1];
                                n_letters_r = i_byte;
                                o_push      = 1'b1;
                                kind        = MSG_GEO_LEFT;
                            end
                        end
                    end
                end
                ACT_SEC_TICK: begin
                    if (r_life_l != 3'd0) begin
                        n_life_l = r_life_l - 3'd1;
                        if (r_life_l == 3'd1) n_leds_l = 8'd0;
                    end
                    if (r_life_r != 3'd0) begin
                        n_life_r = r_life_r - 3'd1;
                        if (r_life_r == 3'd1) n_leds_r = 8'd0;
                    end
                    o_push = 1'b1;
                    kind   = MSG_TICK;
                end
                ACT_FRAME_TICK: begin
                    // only the master (nothing to its left) drives the frame
                    if (r_leds_l == 8'd0) begin
                        if (r_pattern == PAT_WRAP5 || r_pattern == PAT_WRAP2) begin
                            if (frame_inc >= {4'd0, limit}) n_frame = 16'd0;
                            else                            n_frame = frame_inc;
                        end
                        o_push = 1'b1;
                        kind   = MSG_UPDATE;
                    end
                end
                ACT_BUTTON: begin
                    n_bright = (r_bright[6:0] == 7'd0) ? BRIGHT_FLOOR : {r_bright[6:0], 1'b0};
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_msg.kind       = kind;
        o_msg.ll_leds    = i_own_leds + n_leds_r;
        o_msg.ll_letters = i_own_letters + n_letters_r;
        o_msg.rl_leds    = i_own_leds + n_leds_l;
        o_msg.rl_letters = i_own_letters + n_letters_l;
        o_msg.bright     = n_bright;
        o_msg.pattern    = n_pattern;
        o_msg.frame      = n_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leds_l    <= 8'd0;
            r_letters_l <= 8'd0;
            r_life_l    <= 3'd0;
            r_leds_r    <= 8'd0;
            r_letters_r <= 8'd0;
            r_life_r    <= 3'd0;
            r_pattern   <= PATTERN_RESET;
            r_frame     <= 16'd0;
            r_bright    <= BRIGHT_RESET;
            r_lfill     <= 2'd0;
            r_rfill     <= 2'd0;
        end else begin
            r_leds_l    <= n_leds_l;
            r_letters_l <= n_letters_l;
            r_life_l    <= n_life_l;
            r_leds_r    <= n_leds_r;
            r_letters_r <= n_letters_r;
            r_life_r    <= n_life_r;
            r_pattern   <= n_pattern;
            r_frame     <= n_frame;
            r_bright    <= n_bright;
            r_lfill     <= n_lfill;
            r_rfill     <= n_rfill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lbuf_we) r_lbuf[r_lfill] <= i_byte;
        if (rbuf_we) r_rbuf[r_rfill[0]] <= i_byte;
    end

endmodule

`default_nettype wire

### hdl/lclp_queue.sv
`default_nettype none

module lclp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lclp_pkg::t_msg i_msg,
    output logic                o_full,
    output logic                o_empty,
    input  wire logic           i_pop,
    output lclp_pkg::t_msg      o_head
);
    import lclp_pkg::*;

    t_msg              r_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_msg;
    end

endmodule

`default_nettype wire

### hdl/lclp_back.sv
`default_nettype none

module lclp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire lclp_pkg::t_msg i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_byte,
    output logic                o_to_right,
    output logic                o_last
);
    import lclp_pkg::*;

    logic [2:0] r_idx;
    logic       load;
    logic [7:0] cur_byte;
    logic       cur_right, cur_last;

    function automatic logic [7:0] geo_left_byte(input t_msg m, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = HDR_RIGHT_GEO;
            2'd1:    b = m.ll_leds;
            default: b = m.ll_letters;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] geo_right_byte(input t_msg m, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = HDR_LEFT_GEO;
            2'd1:    b = m.rl_leds;
            2'd2:    b = m.rl_letters;
            default: b = m.bright;
        endcase
        return b;
    endfunction

    always_comb begin
        cur_byte  = 8'd0;
        cur_right = 1'b1;
        cur_last  = 1'b0;
        case (i_head.kind)
            MSG_GEO_LEFT: begin
                cur_byte  = geo_left_byte(i_head, r_idx[1:0]);
                cur_right = 1'b0;
                cur_last  = (r_idx == 3'd2);
            end
            MSG_GEO_RIGHT: begin
                cur_byte = geo_right_byte(i_head, r_idx[1:0]);
                cur_last = (r_idx == 3'd3);
            end
            MSG_UPDATE: begin
                case (r_idx[1:0])
                    2'd0:    cur_byte = HDR_UPDATE;
                    2'd1:    cur_byte = i_head.pattern;
                    2'd2:    cur_byte = i_head.frame[15:8];
                    default: cur_byte = i_head.frame[7:0];
                endcase
                cur_last = (r_idx == 3'd3);
            end
            MSG_TICK: begin
                // left geometry first, then right geometry
                if (r_idx < 3'd3) begin
                    cur_byte  = geo_left_byte(i_head, r_idx[1:0]);
                    cur_right = 1'b0;
                end else begin
                    cur_byte = geo_right_byte(i_head, 2'(r_idx - 3'd3));
                end
                cur_last = (r_idx == 3'd6);
            end
            default: begin
            end
        endcase
    end

    assign load  = !i_empty && (!o_valid || i_ready);
    assign o_pop = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            o_valid <= 1'b1;
            r_idx   <= cur_last ? 3'd0 : r_idx + 3'd1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_byte     <= cur_byte;
            o_to_right <= cur_right;
            o_last     <= cur_last;
        end
    end

endmodule

`default_nettype wire

### hdl/led_chain_link_protocol_top.sv
// led chain link node: one board of a left-right daisy chain
//
// input stream (s_axis): one word per event. tuser carries the action code
// (left-link byte, right-link byte, second tick, frame tick, brightness
// button), tdata the received link byte. a word is taken when tvalid and
// tready are both high; tready drops only while the message queue is full.
// output stream (m_axis): the link bytes the node transmits. tdata is the
// byte, tuser says which link (0 left, 1 right), tlast marks the final byte
// caused by one input word. a word moves when tvalid and tready are high.
// an input word that makes a message puts it into the queue; its first
// byte is then loaded into the output register and the rest follow at one
// word per cycle while the receiver is ready. input words are taken every
// cycle while the queue has room, so the sustained rate is set by the output
// serializer: a second tick sends 7 bytes, geometry 3 or 4, an update 4.
// a stalled receiver holds the output register; the queue (4 messages)
// then fills and only then is tready pulled low.
// reset (synchronous, active low) clears neighbor state, frame and framer
// fill counts, sets brightness 255, pattern 1, and the own counts to 8 and 4.
// the apb port writes own_led_count at 0x0 and own_letter_count at 0x4.

`default_nettype none

module led_chain_link_protocol_top #(
    parameter int LIFE_START = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] action
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tuser,   // [0] to_right
    output logic             m_axis_tlast,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lclp_pkg::*;

    logic [7:0] r_own_leds, r_own_letters;
    logic       cfg_we;

    logic       q_push, q_full, q_empty, q_pop;
    t_msg       q_in, q_head;

    // register file, word-addressed by paddr[2]
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = {24'd0, paddr[2] ? r_own_letters : r_own_leds};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_leds    <= OWN_LEDS_RESET;
            r_own_letters <= OWN_LETTERS_RESET;
        end else if (cfg_we) begin
            if (paddr[2]) r_own_letters <= pwdata[7:0];
            else          r_own_leds    <= pwdata[7:0];
        end
    end

    // front: framing, state update, message snapshot
    lclp_front #(
        .LIFE_START (LIFE_START)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_own_leds    (r_own_leds),
        .i_own_letters (r_own_letters),
        .i_valid       (s_axis_tvalid),
        .i_action      (s_axis_tuser),
        .i_byte        (s_axis_tdata),
        .o_ready       (s_axis_tready),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_msg         (q_in)
    );

    // message queue between framer and serializer
    lclp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_msg   (q_in),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // back: byte serializer with output register
    lclp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_to_right (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

endmodule

`default_nettype wire

### hdl/lclp_checker.sv
`default_nettype none

module lclp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast,
    input wire logic        pready
);

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled output word changed");

    // a message is sent without gaps until its last word
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a message");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind led_chain_link_protocol_top lclp_checker u_lclp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lclp_pkg::*;

    localparam int         CLK_HALF       = 6;
    localparam int         RESET_CYCLES   = 11;
    // worst case: ~190 words, each 7 bytes behind the longest stalls, plus source
    // gaps, the long hold and the drains.
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         SQUEEZE_CYCLES = 200;
    localparam int         MAX_REPORTS    = 10;
    localparam int         PHASE_WORDS    = 34;
    localparam logic [2:0] LIFE_RELOAD    = 3'd5;

    localparam logic [2:0] REG_OWN_LEDS    = 3'h0;
    localparam logic [2:0] REG_OWN_LETTERS = 3'h4;

    // action codes the node ignores
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       to_right;
        logic       last;
    } t_link_byte;

    typedef struct packed {
        logic [2:0] act;
        logic [7:0] val;
    } t_link_event;

    // tracks the node state and the link bytes it still owes
    class t_link_node_tracker;
        logic [7:0]  own_leds, own_letters;
        logic [7:0]  leds_l, letters_l, leds_r, letters_r;
        logic [2:0]  life_l, life_r;
        logic [7:0]  pattern, bright;
        logic [15:0] frame;
        logic [7:0]  lbuf [4];
        logic [7:0]  rbuf [3];
        logic [2:0]  lfill;
        logic [1:0]  rfill;
        t_link_byte  link_bytes_due [$];
        int          mismatches;

        function new();
            own_leds    = OWN_LEDS_RESET;
            own_letters = OWN_LETTERS_RESET;
            leds_l      = '0;
            letters_l   = '0;
            life_l      = '0;
            leds_r      = '0;
            letters_r   = '0;
            life_r      = '0;
            pattern     = PATTERN_RESET;
            frame       = '0;
            bright      = BRIGHT_RESET;
            lfill       = '0;
            rfill       = '0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [2:0] addr, logic [7:0] value);
            if (addr == REG_OWN_LEDS) begin
                own_leds = value;
            end else if (addr == REG_OWN_LETTERS) begin
                own_letters = value;
            end
        endfunction

        function void owe(logic [7:0] data, logic to_right);
            t_link_byte entry;
            entry.data     = data;
            entry.to_right = to_right;
            entry.last     = 1'b0;
            link_bytes_due.insert(link_bytes_due.size(), entry);
        endfunction

        function void tell_left_geometry();
            owe(HDR_RIGHT_GEO, 1'b0);
            owe(own_leds + leds_r, 1'b0);
            owe(own_letters + letters_r, 1'b0);
        endfunction

        function void tell_right_geometry();
            owe(HDR_LEFT_GEO, 1'b1);
            owe(own_leds + leds_l, 1'b1);
            owe(own_letters + letters_l, 1'b1);
            owe(bright, 1'b1);
        endfunction

        function void tell_update();
            owe(HDR_UPDATE, 1'b1);
            owe(pattern, 1'b1);
            owe(frame[15:8], 1'b1);
            owe(frame[7:0], 1'b1);
        endfunction

        // advance the node by one accepted input word, queue what it sends
        function void predict_link_bytes(logic [2:0] act, logic [7:0] val);
            int         owed_before;
            int         wrap_at;
            t_link_byte tail;
            owed_before = link_bytes_due.size();
            case (act)
                ACT_LEFT_BYTE: begin
                    // a stray leading byte is dropped
                    if (lfill != 0 || val == HDR_LEFT_GEO || val == HDR_UPDATE) begin
                        lbuf[lfill[1:0]] = val;
                        lfill = lfill + 3'd1;
                        if (lfill == 3'd4) begin
                            lfill = '0;
                            if (lbuf[0] == HDR_LEFT_GEO) begin
                                life_l = LIFE_RELOAD;
                                if (leds_l != lbuf[1] || letters_l != lbuf[2] ||
                                    bright != lbuf[3]) begin
                                    leds_l    = lbuf[1];
                                    letters_l = lbuf[2];
                                    bright    = lbuf[3];
                                    tell_right_geometry();
                                end
                            end else begin
                                pattern = lbuf[1];
                                frame   = {lbuf[2], lbuf[3]};
                                tell_update();
                            end
                        end
                    end
                end
                ACT_RIGHT_BYTE: begin
                    if (rfill != 0 || val == HDR_RIGHT_GEO) begin
                        rbuf[rfill] = val;
                        rfill = rfill + 2'd1;
                        if (rfill == 2'd3) begin
                            rfill  = '0;
                            life_r = LIFE_RELOAD;
                            if (leds_r != rbuf[1] || letters_r != rbuf[2]) begin
                                leds_r    = rbuf[1];
                                letters_r = rbuf[2];
                                tell_left_geometry();
                            end
                        end
                    end
                end
                ACT_SEC_TICK: begin
                    if (life_l != 0) begin
                        life_l = life_l - 3'd1;
                        if (life_l == 0) leds_l = '0;
                    end
                    if (life_r != 0) begin
                        life_r = life_r - 3'd1;
                        if (life_r == 0) leds_r = '0;
                    end
                    tell_left_geometry();
                    tell_right_geometry();
                end
                ACT_FRAME_TICK: begin
                    // only the master (nothing on its left) runs the animation
                    if (leds_l == 0) begin
                        if (pattern == PAT_WRAP5 || pattern == PAT_WRAP2) begin
                            wrap_at = (int'(own_leds) + int'(leds_r)) *
                                      ((pattern == PAT_WRAP5) ? 5 : 2);
                            frame = frame + 16'd1;
                            if (int'(frame) >= wrap_at) frame = '0;
                        end
                        tell_update();
                    end
                end
                ACT_BUTTON: begin
                    bright = {bright[6:0], 1'b0};
                    if (bright == 0) bright = BRIGHT_FLOOR;
                end
                default: begin
                end
            endcase
            if (link_bytes_due.size() > owed_before) begin
                tail = link_bytes_due[link_bytes_due.size() - 1];
                tail.last = 1'b1;
                link_bytes_due[link_bytes_due.size() - 1] = tail;
            end
        endfunction

        function void check_link_byte(logic [7:0] data, logic to_right, logic last);
            t_link_byte want;
            if (link_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word: byte %02h link %0d last %0d",
                             $realtime, data, to_right, last);
                return;
            end
            want = link_bytes_due[0];
            link_bytes_due.delete(0);
            if (want.data !== data || want.to_right !== to_right || want.last !== last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch: expected byte %02h link %0d last %0d, %s %02h %0d %0d",
                             $realtime, want.data, want.to_right, want.last, "got",
                             data, to_right, last);
            end
        endfunction
    endclass

    // clock, reset and all block inputs start at known values
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] byte_value
    logic [2:0]  s_axis_tuser  = '0;    // [2:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] out_byte
    logic        m_axis_tuser;          // [0] to_right
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    t_link_node_tracker tracker;

    bit quiet         = 1'b0;  // last part: no idling on either side
    bit src_gappy     = 1'b1;
    bit squeeze_armed = 1'b0;
    int squeeze_from  = 0;
    int tx_words      = 0;

    // opening checks: stray bytes, both geometry kinds, brightness wrap to
    // the floor, frame wrap at 16 bits, a held pattern, ignored codes, and a
    // frame tick on a non-master
    t_link_event directed_events [30] = '{
        {ACT_FRAME_TICK, 8'h00},
        {ACT_LEFT_BYTE,  8'hFF},
        {ACT_RIGHT_BYTE, 8'h00},
        {ACT_LEFT_BYTE,  HDR_LEFT_GEO},
        {ACT_LEFT_BYTE,  8'h00},
        {ACT_LEFT_BYTE,  8'hFF},
        {ACT_LEFT_BYTE,  8'h80},
        {ACT_BUTTON,     8'h00},
        {ACT_BUTTON,     8'hFF},
        {ACT_RIGHT_BYTE, HDR_RIGHT_GEO},
        {ACT_RIGHT_BYTE, 8'hFF},
        {ACT_RIGHT_BYTE, 8'hFF},
        {ACT_LEFT_BYTE,  HDR_UPDATE},
        {ACT_LEFT_BYTE,  PAT_WRAP5},
        {ACT_LEFT_BYTE,  8'hFF},
        {ACT_LEFT_BYTE,  8'hFF},
        {ACT_FRAME_TICK, 8'h00},
        {ACT_LEFT_BYTE,  HDR_UPDATE},
        {ACT_LEFT_BYTE,  8'h07},
        {ACT_LEFT_BYTE,  8'h12},
        {ACT_LEFT_BYTE,  8'h34},
        {ACT_FRAME_TICK, 8'h00},
        {ACT_SEC_TICK,   8'h00},
        {ACT_SPARE_LO,   8'h5A},
        {ACT_SPARE_HI,   8'hA5},
        {ACT_LEFT_BYTE,  HDR_LEFT_GEO},
        {ACT_LEFT_BYTE,  8'h05},
        {ACT_LEFT_BYTE,  8'h03},
        {ACT_LEFT_BYTE,  8'h14},
        {ACT_FRAME_TICK, 8'h00}
    };

    led_chain_link_protocol_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // offer one input word, hold it until taken, then predict its bytes
    task automatic offer_word(input logic [2:0] act, input logic [7:0] val);
        @(negedge i_clk);
        if (src_gappy && !quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.predict_link_bytes(act, val);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [2:0] addr, input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_register(addr, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, wait for every owed byte, then let the queue settle
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.link_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly whole frames with random content, plus ticks, presses and noise
    task automatic run_random_phase(input int target);
        int          sent;
        int          pick;
        logic [7:0]  hdr, b1, b2, b3;
        logic [2:0]  act_pick;
        logic [15:0] frame_val;
        sent = 0;
        while (sent < target) begin
            src_gappy = !quiet && ($urandom_range(0, 9) < 6);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // realign the left framer first, most of the time
                if (tracker.lfill != 0 && $urandom_range(0, 9) < 7) begin
                    repeat (4 - tracker.lfill) begin
                        offer_word(ACT_LEFT_BYTE, 8'($urandom));
                        sent++;
                    end
                end
                if ($urandom_range(0, 9) < 6) begin
                    hdr = HDR_LEFT_GEO;
                    if ($urandom_range(0, 9) < 3) begin
                        // same geometry again: no forwarding
                        b1 = tracker.leds_l;
                        b2 = tracker.letters_l;
                        b3 = tracker.bright;
                    end else begin
                        b1 = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
                        b2 = 8'($urandom);
                        b3 = 8'($urandom);
                    end
                end else begin
                    hdr = HDR_UPDATE;
                    case ($urandom_range(0, 4))
                        0, 1:    b1 = PAT_WRAP5;
                        2, 3:    b1 = PAT_WRAP2;
                        default: b1 = 8'($urandom);
                    endcase
                    // small frames keep the wrap points within reach
                    frame_val = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 40))
                                                           : 16'($urandom);
                    b2 = frame_val[15:8];
                    b3 = frame_val[7:0];
                end
                offer_word(ACT_LEFT_BYTE, hdr);
                offer_word(ACT_LEFT_BYTE, b1);
                offer_word(ACT_LEFT_BYTE, b2);
                offer_word(ACT_LEFT_BYTE, b3);
                sent += 4;
            end else if (pick < 50) begin
                if (tracker.rfill != 0 && $urandom_range(0, 9) < 7) begin
                    repeat (3 - tracker.rfill) begin
                        offer_word(ACT_RIGHT_BYTE, 8'($urandom));
                        sent++;
                    end
                end
                if ($urandom_range(0, 9) < 3) begin
                    b1 = tracker.leds_r;
                    b2 = tracker.letters_r;
                end else begin
                    b1 = 8'($urandom);
                    b2 = 8'($urandom);
                end
                offer_word(ACT_RIGHT_BYTE, HDR_RIGHT_GEO);
                offer_word(ACT_RIGHT_BYTE, b1);
                offer_word(ACT_RIGHT_BYTE, b2);
                sent += 3;
            end else if (pick < 65) begin
                offer_word(ACT_SEC_TICK, 8'($urandom));
                sent++;
            end else if (pick < 85) begin
                offer_word(ACT_FRAME_TICK, 8'($urandom));
                sent++;
            end else if (pick < 90) begin
                offer_word(ACT_BUTTON, 8'($urandom));
                sent++;
            end else if (pick < 97) begin
                // noise: a lone header that breaks framing, or any byte
                act_pick = $urandom_range(0, 1) ? ACT_LEFT_BYTE : ACT_RIGHT_BYTE;
                if ($urandom_range(0, 1)) begin
                    b1 = (act_pick == ACT_LEFT_BYTE) ? HDR_UPDATE : HDR_RIGHT_GEO;
                end else begin
                    b1 = 8'($urandom);
                end
                offer_word(act_pick, b1);
                sent++;
            end else begin
                offer_word(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 8'($urandom));
                sent++;
            end
        end
    endtask

    // output side: random stall bursts, calm stretches, one long hold-off
    initial begin : sink
        int hold_left;
        bit squeeze_done;
        bit sink_gappy;
        hold_left    = 0;
        squeeze_done = 1'b0;
        sink_gappy   = 1'b1;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) == 0) sink_gappy = !sink_gappy;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (squeeze_armed && !squeeze_done && tx_words >= squeeze_from) begin
                // long hold while the source keeps offering: queue fills, input stalls
                squeeze_done  = 1'b1;
                hold_left     = SQUEEZE_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (sink_gappy && !quiet && $urandom_range(0, 7) == 0) begin
                hold_left     = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // every word that leaves is checked against the oldest owed byte
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_link_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            tx_words = tx_words + 1;
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, directed words
        src_gappy = 1'b1;
        foreach (directed_events[k])
            offer_word(directed_events[k].act, directed_events[k].val);
        wait_drained();

        // smallest board
        reg_write(REG_OWN_LEDS, 8'd1);
        reg_write(REG_OWN_LETTERS, 8'd0);
        run_random_phase(PHASE_WORDS);
        wait_drained();

        // largest board, sums wrap; the long hold-off lands here
        reg_write(REG_OWN_LEDS, 8'd255);
        reg_write(REG_OWN_LETTERS, 8'd255);
        squeeze_from  = tx_words + 8;
        squeeze_armed = 1'b1;
        run_random_phase(PHASE_WORDS);
        wait_drained();

        reg_write(REG_OWN_LEDS, 8'($urandom_range(1, 255)));
        reg_write(REG_OWN_LETTERS, 8'($urandom));
        run_random_phase(PHASE_WORDS);
        wait_drained();

        // full rate to the end
        quiet = 1'b1;
        reg_write(REG_OWN_LEDS, 8'($urandom_range(1, 255)));
        reg_write(REG_OWN_LETTERS, 8'($urandom));
        run_random_phase(PHASE_WORDS);
        wait_drained();

        if (tracker.mismatches == 0 && tracker.link_bytes_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hdl/lclp_pkg.sv
hdl/lclp_front.sv
hdl/lclp_queue.sv
hdl/lclp_back.sv
hdl/led_chain_link_protocol_top.sv
hdl/lclp_checker.sv
sim/tb_top.sv
